// ===== rtl/utf8_text_position_tracker_unit_macros.svh =====
// Assertion macros shared by the text position tracker RTL.
`ifndef UTF8_TEXT_POSITION_TRACKER_UNIT_MACROS_SVH
`define UTF8_TEXT_POSITION_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UTPT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UTPT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/utpt_pkg.sv =====
// Shared types and constants of the UTF-8 text position tracker.
`default_nettype none

package utpt_pkg;

    // Fixed payload field widths
    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int UNITS_W    = 2;
    localparam int LINE_FW    = 24;
    localparam int COLUMN_FW  = 16;
    localparam int OFFSET_FW  = 32;
    localparam int LEN_W      = 3;
    localparam int CNT_W      = 2;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [CP_W-1:0]   CP_LF   = 21'h00000A;
    localparam logic [CP_W-1:0]   CP_REPL = 21'h00FFFD;
    localparam logic [CP_W-1:0]   CP_BMP_TOP = 21'h00FFFF;

    // Lead and continuation byte patterns
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Results owed for one accepted byte: replacements, at most one code point,
    // then replacements flushed at end of text.
    typedef struct packed {
        logic [CNT_W-1:0] pre_cnt;
        logic             pt_valid;
        logic [CP_W-1:0]  pt_cp;
        logic [LEN_W-1:0] pt_len;
        logic             pt_repl;
        logic [CNT_W-1:0] post_cnt;
        logic             eot;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/utpt_in_if.sv =====
// Input channel: one raw text byte per transaction.
`default_nettype none

interface utpt_in_if;
    logic                          valid;
    logic                          ready;
    logic [utpt_pkg::BYTE_W-1:0]   text_byte;
    logic                          end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/utpt_out_if.sv =====
// Output channel: one decoded code point with its position per transaction.
`default_nettype none

interface utpt_out_if;
    logic                            valid;
    logic                            ready;
    logic [utpt_pkg::CP_W-1:0]       code_point;
    logic [utpt_pkg::UNITS_W-1:0]    unit_count;
    logic [utpt_pkg::LINE_FW-1:0]    line_number;
    logic [utpt_pkg::COLUMN_FW-1:0]  column_units;
    logic [utpt_pkg::OFFSET_FW-1:0]  byte_offset;
    logic                            replaced;
    logic                            last_of_item;

    modport source (output valid, output code_point, output unit_count,
                    output line_number, output column_units, output byte_offset,
                    output replaced, output last_of_item, input ready);
    modport sink   (input valid, input code_point, input unit_count,
                    input line_number, input column_units, input byte_offset,
                    input replaced, input last_of_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8_text_position_tracker_unit.sv =====
// Top level of the UTF-8 text position tracker: job register, emitter, counters.
// A byte that yields at most one code point is taken every cycle while the output
// is not stalled, passing through the job register and then the output register.
// A byte that yields k results (up to four: replacements for a broken or cut-off
// sequence plus the new point) holds the input until its last result is emitted,
// because the emitter puts out one result per cycle while the output is not
// stalled, and owns the line, column and offset counters. A dropped LF that does
// not end the text skips the job register; a final byte with nothing to emit
// still enters it to clear the counters. Counters saturate at LINE_BITS,
// COLUMN_BITS and OFFSET_BITS all-ones and are shown in the fixed field widths.
`default_nettype none
`include "utf8_text_position_tracker_unit_macros.svh"

module utf8_text_position_tracker_unit #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    utpt_in_if.sink    text_in,
    utpt_out_if.source point_out
);

    localparam int LINE_WW   = LINE_BITS > utpt_pkg::LINE_FW ? LINE_BITS : utpt_pkg::LINE_FW;
    localparam int COLUMN_WW = COLUMN_BITS > utpt_pkg::COLUMN_FW ?
                               COLUMN_BITS : utpt_pkg::COLUMN_FW;
    localparam int OFFSET_WW = OFFSET_BITS > utpt_pkg::OFFSET_FW ?
                               OFFSET_BITS : utpt_pkg::OFFSET_FW;

    utpt_pkg::job_t decoded;
    utpt_pkg::job_t job_reg, job_next;
    logic           job_valid_reg;

    logic           in_fire;
    logic           advance;
    logic           sel_pre, sel_pt, sel_post, emit_any, emit_fire;
    logic           remaining, job_done;
    logic [2:0]     job_total;

    logic [utpt_pkg::CP_W-1:0]    emit_cp;
    logic [utpt_pkg::LEN_W-1:0]   emit_len;
    logic                         emit_repl;
    logic [utpt_pkg::UNITS_W-1:0] emit_units;

    logic [LINE_BITS-1:0]   line_reg, line_next, line_inc;
    logic [COLUMN_BITS-1:0] col_reg, col_next, col_inc;
    logic [OFFSET_BITS-1:0] off_reg, off_next, off_inc;
    logic [LINE_BITS:0]     line_sum;
    logic [COLUMN_BITS:0]   col_sum;
    logic [OFFSET_BITS:0]   off_sum;

    logic [LINE_WW-1:0]     line_wide;
    logic [COLUMN_WW-1:0]   col_wide;
    logic [OFFSET_WW-1:0]   off_wide;

    logic                             out_valid_reg;
    logic [utpt_pkg::CP_W-1:0]        out_cp_reg;
    logic [utpt_pkg::UNITS_W-1:0]     out_units_reg;
    logic [utpt_pkg::LINE_FW-1:0]     out_line_reg;
    logic [utpt_pkg::COLUMN_FW-1:0]   out_col_reg;
    logic [utpt_pkg::OFFSET_FW-1:0]   out_off_reg;
    logic                             out_repl_reg;
    logic                             out_last_reg;

    // Decode each accepted byte into the results it owes
    utpt_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .text_byte   (text_in.text_byte),
        .end_of_text (text_in.end_of_text),
        .job         (decoded)
    );

    // Pick the next result of the held job
    always_comb
    begin
        advance   = job_valid_reg && (!out_valid_reg || point_out.ready);
        sel_pre   = job_reg.pre_cnt != '0;
        sel_pt    = !sel_pre && job_reg.pt_valid;
        sel_post  = !sel_pre && !job_reg.pt_valid && job_reg.post_cnt != '0;
        emit_any  = sel_pre || sel_pt || sel_post;
        emit_fire = advance && emit_any;

        job_next = job_reg;
        if (sel_pre)
        begin
            job_next.pre_cnt = job_reg.pre_cnt - utpt_pkg::CNT_W'(1);
        end
        else if (sel_pt)
        begin
            job_next.pt_valid = 1'b0;
        end
        else if (sel_post)
        begin
            job_next.post_cnt = job_reg.post_cnt - utpt_pkg::CNT_W'(1);
        end
        remaining = job_next.pre_cnt != '0 || job_next.pt_valid || job_next.post_cnt != '0;
        job_done  = advance && !remaining;

        emit_cp    = sel_pt ? job_reg.pt_cp   : utpt_pkg::CP_REPL;
        emit_len   = sel_pt ? job_reg.pt_len  : utpt_pkg::LEN_ONE;
        emit_repl  = sel_pt ? job_reg.pt_repl : 1'b1;
        emit_units = emit_cp > utpt_pkg::CP_BMP_TOP ? 2'd2 : 2'd1;

        job_total = 3'(job_reg.pre_cnt) + 3'(job_reg.pt_valid) + 3'(job_reg.post_cnt);
    end

    assign text_in.ready = !job_valid_reg || job_done;
    assign in_fire       = text_in.valid && text_in.ready;

    // Hold the job until its last result leaves; skip bytes that owe nothing unless they end the text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            job_valid_reg <= decoded.eot || decoded.pre_cnt != '0 || decoded.pt_valid ||
                             decoded.post_cnt != '0;
        end
        else if (job_done)
        begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            job_reg <= decoded;
        end
        else if (emit_fire)
        begin
            job_reg <= job_next;
        end
    end

    // Saturating position increments
    always_comb
    begin
        line_sum = {1'b0, line_reg} + (LINE_BITS + 1)'(1);
        col_sum  = {1'b0, col_reg} + (COLUMN_BITS + 1)'(emit_units);
        off_sum  = {1'b0, off_reg} + (OFFSET_BITS + 1)'(emit_len);
        line_inc = line_sum[LINE_BITS]   ? '1 : line_sum[LINE_BITS-1:0];
        col_inc  = col_sum[COLUMN_BITS]  ? '1 : col_sum[COLUMN_BITS-1:0];
        off_inc  = off_sum[OFFSET_BITS]  ? '1 : off_sum[OFFSET_BITS-1:0];

        line_next = line_reg;
        col_next  = col_reg;
        off_next  = off_reg;
        if (emit_fire)
        begin
            off_next = off_inc;
            if (emit_cp == utpt_pkg::CP_LF)
            begin
                line_next = line_inc;
                col_next  = '0;
            end
            else
            begin
                col_next = col_inc;
            end
        end
        // Clear positions once the final byte is fully delivered
        if (job_done && job_reg.eot)
        begin
            line_next = '0;
            col_next  = '0;
            off_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            col_reg  <= '0;
            off_reg  <= '0;
        end
        else
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
            off_reg  <= off_next;
        end
    end

    // Fit counters to the fixed field widths
    assign line_wide = LINE_WW'(line_reg);
    assign col_wide  = COLUMN_WW'(col_reg);
    assign off_wide  = OFFSET_WW'(off_reg);

    // Output register: load on emit, drop once the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (point_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_cp_reg    <= emit_cp;
            out_units_reg <= emit_units;
            out_line_reg  <= line_wide[utpt_pkg::LINE_FW-1:0];
            out_col_reg   <= col_wide[utpt_pkg::COLUMN_FW-1:0];
            out_off_reg   <= off_wide[utpt_pkg::OFFSET_FW-1:0];
            out_repl_reg  <= emit_repl;
            out_last_reg  <= !remaining;
        end
    end

    assign point_out.valid        = out_valid_reg;
    assign point_out.code_point   = out_cp_reg;
    assign point_out.unit_count   = out_units_reg;
    assign point_out.line_number  = out_line_reg;
    assign point_out.column_units = out_col_reg;
    assign point_out.byte_offset  = out_off_reg;
    assign point_out.replaced     = out_repl_reg;
    assign point_out.last_of_item = out_last_reg;

    // Checks
    `UTPT_ASSERT_IMP(a_job_bound, job_valid_reg, job_total <= 3'd4,
        "job owes more than four results")
    `UTPT_ASSERT_NXT(a_eot_clear, job_done && job_reg.eot,
        line_reg == '0 && col_reg == '0 && off_reg == '0,
        "positions not cleared after end of text")
    `UTPT_ASSERT_NXT(a_last_mark, emit_fire && !remaining,
        out_valid_reg && out_last_reg, "final result of a byte not marked last")

endmodule

`default_nettype wire

// ===== rtl/utpt_decode.sv =====
// Newline folding and UTF-8 sequence decoding into a per-byte result job.
`default_nettype none

module utpt_decode (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire logic [utpt_pkg::BYTE_W-1:0] text_byte,
    input  wire logic                        end_of_text,
    output utpt_pkg::job_t                   job
);

    logic [utpt_pkg::CNT_W-1:0] held_reg, held_next;
    logic [utpt_pkg::LEN_W-1:0] exp_len_reg, exp_len_next;
    logic [utpt_pkg::CP_W-1:0]  partial_reg, partial_next;
    logic                       cr_reg, cr_next;

    logic [utpt_pkg::BYTE_W-1:0] fb;
    logic                        do_feed;
    logic                        fresh;
    logic [utpt_pkg::CP_W-1:0]   cont_cp;

    assign cont_cp = {partial_reg[utpt_pkg::CP_W-7:0], fb[5:0]};

    // Fold newlines, continue or break the held sequence, flush at end of text
    always_comb
    begin
        fb           = text_byte;
        do_feed      = 1'b1;
        cr_next      = 1'b0;
        fresh        = 1'b0;
        held_next    = held_reg;
        exp_len_next = exp_len_reg;
        partial_next = partial_reg;
        job          = '0;
        job.pt_len   = utpt_pkg::LEN_ONE;
        job.eot      = end_of_text;

        if (text_byte == utpt_pkg::CHAR_CR)
        begin
            fb      = utpt_pkg::CHAR_LF;
            cr_next = 1'b1;
        end
        else if (text_byte == utpt_pkg::CHAR_LF && cr_reg)
        begin
            do_feed = 1'b0;
        end

        if (do_feed)
        begin
            if (held_reg == '0)
            begin
                fresh = 1'b1;
            end
            else if ((fb & utpt_pkg::MASK_CONT) == utpt_pkg::PAT_CONT)
            begin
                if ({1'b0, held_reg} + utpt_pkg::LEN_ONE >= exp_len_reg)
                begin
                    job.pt_valid = 1'b1;
                    job.pt_cp    = cont_cp;
                    job.pt_len   = exp_len_reg;
                    held_next    = '0;
                    exp_len_next = '0;
                    partial_next = '0;
                end
                else
                begin
                    held_next    = held_reg + utpt_pkg::CNT_W'(1);
                    partial_next = cont_cp;
                end
            end
            else
            begin
                // Broken sequence: one replacement per held byte, then decode afresh
                job.pre_cnt  = held_reg;
                held_next    = '0;
                exp_len_next = '0;
                partial_next = '0;
                fresh        = 1'b1;
            end
        end

        if (fresh)
        begin
            if (fb[7] == 1'b0)
            begin
                job.pt_valid = 1'b1;
                job.pt_cp    = utpt_pkg::CP_W'(fb);
            end
            else if ((fb & utpt_pkg::MASK_LEAD2) == utpt_pkg::PAT_LEAD2)
            begin
                held_next    = utpt_pkg::CNT_W'(1);
                exp_len_next = utpt_pkg::LEN_TWO;
                partial_next = utpt_pkg::CP_W'(fb[4:0]);
            end
            else if ((fb & utpt_pkg::MASK_LEAD3) == utpt_pkg::PAT_LEAD3)
            begin
                held_next    = utpt_pkg::CNT_W'(1);
                exp_len_next = utpt_pkg::LEN_THREE;
                partial_next = utpt_pkg::CP_W'(fb[3:0]);
            end
            else if ((fb & utpt_pkg::MASK_LEAD4) == utpt_pkg::PAT_LEAD4)
            begin
                held_next    = utpt_pkg::CNT_W'(1);
                exp_len_next = utpt_pkg::LEN_FOUR;
                partial_next = utpt_pkg::CP_W'(fb[2:0]);
            end
            else
            begin
                job.pt_valid = 1'b1;
                job.pt_cp    = utpt_pkg::CP_REPL;
                job.pt_repl  = 1'b1;
            end
        end

        // Flush what is still held and return to the start state
        if (end_of_text)
        begin
            job.post_cnt = held_next;
            held_next    = '0;
            exp_len_next = '0;
            partial_next = '0;
            cr_next      = 1'b0;
        end
    end

    // Advance decoder state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            exp_len_reg <= '0;
            partial_reg <= '0;
            cr_reg      <= 1'b0;
        end
        else if (fire)
        begin
            held_reg    <= held_next;
            exp_len_reg <= exp_len_next;
            partial_reg <= partial_next;
            cr_reg      <= cr_next;
        end
    end

endmodule

`default_nettype wire
